### hw/rtl/pfh_pkg.sv
// Package for the packet fragmenter with header.
// Holds frame sizing constants, header codes and the result word type.
// No dependencies.
package pfh_pkg;

  localparam int unsigned FRAME_BYTES  = 102;
  localparam int unsigned FRAG_PAYLOAD = 100;
  localparam int unsigned MAX_PACKET   = 1500;
  localparam int unsigned HDR_BYTES    = 2;
  localparam int unsigned RES_DEPTH    = 3;

  localparam logic [7:0] TAG_WRAP  = 8'hFE;
  localparam logic [7:0] TAG_FIRST = 8'h01;
  localparam logic [7:0] FNO_WHOLE = 8'h00;
  localparam logic [7:0] FNO_LAST  = 8'hFF;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic [7:0] frame_length;
    logic [7:0] fragment_number;
    logic [7:0] packet_tag;
    logic [5:0] option_bits;
    logic       too_long;
    logic       last;
  } res_t;

endpackage

### hw/rtl/packet_fragmenter_with_header_top.sv
// Top level of the packet fragmenter with header.
// Splits payload bytes into frames with a 2-byte header; uses pfh_pkg.
//
// Usage:
//   Slave channel s_axis_*: one payload byte per word. tuser marks the first
//   word of a packet, which also carries the packet length and send options.
//   Master channel m_axis_*: one frame byte per word; tlast marks the final
//   byte of a frame. A frame opens with the tag byte and the fragment number.
//   The first result word of an accepted word is shown in the cycle after it
//   is accepted. A payload byte gives one result word, so a packet streams at
//   one byte per cycle while the receiver takes every word; the first byte
//   of each frame gives three result words and holds tready low while the
//   header goes out. An oversize packet gives one flagged word and its bytes
//   are dropped. The result buffer holds up to three words; a new word is
//   taken while the last buffered result is being taken, so the input and
//   output run at the same time.
//   Reset empties the buffer and clears the tag counter and the packet state.
//   When the receiver stalls the buffered word holds and tready stays low
//   while any word is waiting.
module packet_fragmenter_with_header_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], packet_length[18:8], want_indication[19], unack_csma[20],
  // max_hops[24:21], zero[31:25]
  input  logic [31:0] s_axis_tdata,
  // first_item[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], frame_length[15:8], fragment_number[23:16],
  // packet_tag[31:24], option_bits[37:32], zero[39:38]
  output logic [39:0] m_axis_tdata,
  // frame_end
  output logic        m_axis_tlast,
  // frame_start[0], too_long[1], last[2]
  output logic [2:0]  m_axis_tuser
);
  import pfh_pkg::*;

  logic [7:0]  tag_q, tag_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  fidx_q, fidx_d;
  logic [7:0]  bif_q, bif_d;
  logic [5:0]  opt_q, opt_d;
  logic        frag_q, frag_d;
  logic        drop_q, drop_d;
  logic [7:0]  fp_q, fp_d;
  logic [7:0]  fno_q, fno_d;

  res_t        buf_q [RES_DEPTH];
  res_t        res_d [RES_DEPTH];
  logic [1:0]  cnt_q, n_d;

  logic        s_fire, m_fire;

  logic [7:0]  in_byte;
  logic        in_first;
  logic [10:0] in_len;
  logic [5:0]  in_opt;
  logic [11:0] len_hdr;

  logic [10:0] e_rem;
  logic [7:0]  e_bif, e_fidx, e_tag;
  logic        e_frag, go;
  logic [7:0]  cur_fp, cur_fno, flen, bif_inc;
  logic        fend;
  res_t        blank;

  assign in_byte  = s_axis_tdata[7:0];
  assign in_len   = s_axis_tdata[18:8];
  assign in_opt   = {s_axis_tdata[24:21], s_axis_tdata[20], s_axis_tdata[19]};
  assign in_first = s_axis_tuser;
  assign len_hdr  = {1'b0, in_len} + 12'(HDR_BYTES);

  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    tag_d   = tag_q;
    rem_d   = rem_q;
    fidx_d  = fidx_q;
    bif_d   = bif_q;
    opt_d   = opt_q;
    frag_d  = frag_q;
    drop_d  = drop_q;
    fp_d    = fp_q;
    fno_d   = fno_q;
    n_d     = 2'd0;
    e_rem   = rem_q;
    e_bif   = bif_q;
    e_fidx  = fidx_q;
    e_tag   = tag_q;
    e_frag  = frag_q;
    go      = 1'b0;
    cur_fp  = fp_q;
    cur_fno = fno_q;
    flen    = 8'd0;
    bif_inc = 8'd0;
    fend    = 1'b0;
    blank   = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_d[i] = '0;
    end

    if (in_first) begin
      opt_d  = in_opt;
      rem_d  = '0;
      bif_d  = '0;
      fidx_d = '0;
      drop_d = 1'b0;
      if (in_len > 11'(MAX_PACKET)) begin
        drop_d            = 1'b1;
        blank.packet_tag  = tag_q;
        blank.option_bits = in_opt;
        blank.too_long    = 1'b1;
        blank.last        = 1'b1;
        res_d[0]          = blank;
        n_d               = 2'd1;
      end else begin
        e_tag  = (tag_q >= TAG_WRAP) ? TAG_FIRST : tag_q + 8'd1;
        tag_d  = e_tag;
        rem_d  = in_len;
        e_frag = len_hdr > 12'(FRAME_BYTES);
        frag_d = e_frag;
        e_rem  = in_len;
        e_bif  = '0;
        e_fidx = '0;
        if (in_len == 11'd0) begin
          blank.packet_tag      = e_tag;
          blank.option_bits     = in_opt;
          blank.frame_length    = 8'(HDR_BYTES);
          blank.fragment_number = FNO_WHOLE;
          res_d[0]             = blank;
          res_d[0].out_byte    = e_tag;
          res_d[0].frame_start = 1'b1;
          res_d[1]             = blank;
          res_d[1].out_byte    = FNO_WHOLE;
          res_d[1].frame_end   = 1'b1;
          res_d[1].last        = 1'b1;
          n_d                  = 2'd2;
        end else begin
          go = 1'b1;
        end
      end
    end else if (!drop_q && (rem_q != 11'd0)) begin
      go = 1'b1;
    end

    if (go) begin
      blank.packet_tag  = e_tag;
      blank.option_bits = in_first ? in_opt : opt_q;
      if (e_bif == 8'd0) begin
        fidx_d = e_fidx + 8'd1;
        if (!e_frag) begin
          cur_fp  = e_rem[7:0];
          cur_fno = FNO_WHOLE;
        end else if (e_rem <= 11'(FRAG_PAYLOAD)) begin
          cur_fp  = e_rem[7:0];
          cur_fno = FNO_LAST;
        end else begin
          cur_fp  = 8'(FRAG_PAYLOAD);
          cur_fno = fidx_d;
        end
        fp_d  = cur_fp;
        fno_d = cur_fno;
      end
      flen                  = cur_fp + 8'(HDR_BYTES);
      blank.frame_length    = flen;
      blank.fragment_number = cur_fno;
      bif_inc               = e_bif + 8'd1;
      fend                  = bif_inc >= cur_fp;
      rem_d                 = e_rem - 11'd1;
      bif_d                 = fend ? 8'd0 : bif_inc;
      if (e_bif == 8'd0) begin
        res_d[0]             = blank;
        res_d[0].out_byte    = e_tag;
        res_d[0].frame_start = 1'b1;
        res_d[1]             = blank;
        res_d[1].out_byte    = cur_fno;
        res_d[2]             = blank;
        res_d[2].out_byte    = in_byte;
        res_d[2].frame_end   = fend;
        res_d[2].last        = 1'b1;
        n_d                  = 2'd3;
      end else begin
        res_d[0]           = blank;
        res_d[0].out_byte  = in_byte;
        res_d[0].frame_end = fend;
        res_d[0].last      = 1'b1;
        n_d                = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      rem_q  <= '0;
      fidx_q <= '0;
      bif_q  <= '0;
      opt_q  <= '0;
      frag_q <= 1'b0;
      drop_q <= 1'b0;
      fp_q   <= '0;
      fno_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (s_fire) begin
        tag_q  <= tag_d;
        rem_q  <= rem_d;
        fidx_q <= fidx_d;
        bif_q  <= bif_d;
        opt_q  <= opt_d;
        frag_q <= frag_d;
        drop_q <= drop_d;
        fp_q   <= fp_d;
        fno_q  <= fno_d;
        cnt_q  <= n_d;
      end else if (m_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        buf_q[i] <= res_d[i];
      end
    end else if (m_fire) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {2'b00, buf_q[0].option_bits, buf_q[0].packet_tag,
                          buf_q[0].fragment_number, buf_q[0].frame_length,
                          buf_q[0].out_byte};
  assign m_axis_tlast  = buf_q[0].frame_end;
  assign m_axis_tuser  = {buf_q[0].last, buf_q[0].too_long, buf_q[0].frame_start};

`ifndef SYNTH
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_fire))
    else $error("word accepted while results still pending");

  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q != FNO_LAST)
    else $error("tag counter left its range");

  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> rem_q == 11'd0)
    else $error("bytes pending while dropping a packet");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && buf_q[0].too_long) |-> (buf_q[0].last && !buf_q[0].frame_start))
    else $error("rejection word malformed");

  a_start_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && buf_q[0].frame_start) |-> !buf_q[0].frame_end && !buf_q[0].last)
    else $error("tag byte closes a frame");
`endif

endmodule
